>>> rtl/core/assert_macros.svh
// Assertion macros shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MFISP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mfisp assertion failed");
`define MFISP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mfisp assertion failed");
`else
`define MFISP_ASSERT(lbl, clk, rstn, prop)
`define MFISP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/core/mfisp_pkg.sv
// Types and constants for the framed image stream parser.
`timescale 1ns / 1ps
`default_nettype none

package mfisp_pkg;

  localparam logic [31:0] MAGIC_IMAGE     = 32'h5653_544A;
  localparam logic [31:0] MAGIC_STATE     = 32'h5653_5453;
  localparam logic [2:0]  HEADER_LAST_IDX = 3'd6;
  localparam logic [2:0]  WINDOW_FULL     = 3'd4;
  localparam logic [15:0] GAP_RESET       = 16'd500;

  localparam logic [2:0] HIDX_STATUS = 3'd0;
  localparam logic [2:0] HIDX_CLASS  = 3'd1;
  localparam logic [2:0] HIDX_CONF   = 3'd2;
  localparam logic [2:0] HIDX_LEN1   = 3'd4;
  localparam logic [2:0] HIDX_LEN2   = 3'd5;
  localparam logic [2:0] HIDX_LEN3   = 3'd6;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        frame_start;
    logic        frame_accepted;
    logic [7:0]  frame_status;
    logic [7:0]  frame_class;
    logic [7:0]  frame_confidence;
    logic [31:0] frame_length;
    logic [31:0] frame_count;
    logic        payload_valid;
    logic        payload_last;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/mfisp_core.sv
// Parser state registers and the single-pass next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mfisp_core import mfisp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        action,
  input  wire logic [7:0]  data_byte,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  output result_t          res
);

  logic [15:0] gap_r;
  logic [31:0] window_r, window_nxt;
  logic [2:0]  fill_r, fill_nxt;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  conf_r, conf_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic        acc_r, acc_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] last_r, last_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] elapsed;
  logic        start, pvalid, plast;
  logic [7:0]  pbyte;

  assign elapsed = time_r - last_r;

  always_comb begin
    window_nxt = window_r;
    fill_nxt   = fill_r;
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    status_nxt = status_r;
    class_nxt  = class_r;
    conf_nxt   = conf_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    acc_nxt    = acc_r;
    time_nxt   = time_r;
    last_nxt   = last_r;
    count_nxt  = count_r;
    start      = 1'b0;
    pvalid     = 1'b0;
    plast      = 1'b0;
    pbyte      = 8'd0;
    if (push) begin
      if (action) begin
        time_nxt = time_r + 32'd1;
      end else begin
        case (phase_r)
          PH_SKIP: begin
            phase_nxt = PH_HUNT;
          end
          PH_HEADER: begin
            case (hidx_r)
              HIDX_STATUS: status_nxt     = data_byte;
              HIDX_CLASS:  class_nxt      = data_byte;
              HIDX_CONF:   conf_nxt       = data_byte;
              HIDX_LEN1:   len_nxt[15:8]  = data_byte;
              HIDX_LEN2:   len_nxt[23:16] = data_byte;
              HIDX_LEN3:   len_nxt[31:24] = data_byte;
              default:     len_nxt[7:0]   = data_byte;
            endcase
            if (hidx_r == HEADER_LAST_IDX) begin
              hidx_nxt = 3'd0;
              start    = 1'b1;
              if (elapsed < {16'd0, gap_r}) begin
                acc_nxt = 1'b0;
              end else begin
                acc_nxt   = 1'b1;
                last_nxt  = time_r;
                count_nxt = count_r + 32'd1;
              end
              remain_nxt = len_nxt;
              phase_nxt  = (len_nxt == 32'd0) ? PH_HUNT : PH_DATA;
            end else begin
              hidx_nxt = hidx_r + 3'd1;
            end
          end
          PH_DATA: begin
            pvalid = 1'b1;
            pbyte  = data_byte;
            if (remain_r <= 32'd1) begin
              plast      = 1'b1;
              remain_nxt = 32'd0;
              phase_nxt  = PH_HUNT;
            end else begin
              remain_nxt = remain_r - 32'd1;
            end
          end
          default: begin
            window_nxt = {window_r[23:0], data_byte};
            if (fill_r < WINDOW_FULL) begin
              fill_nxt = fill_r + 3'd1;
            end
            if (fill_nxt == WINDOW_FULL) begin
              if (window_nxt == MAGIC_STATE) begin
                phase_nxt = PH_SKIP;
              end else if (window_nxt == MAGIC_IMAGE) begin
                phase_nxt = PH_HEADER;
                hidx_nxt  = 3'd0;
                len_nxt   = 32'd0;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r    <= GAP_RESET;
      window_r <= 32'd0;
      fill_r   <= 3'd0;
      phase_r  <= PH_HUNT;
      hidx_r   <= 3'd0;
      status_r <= 8'd0;
      class_r  <= 8'd0;
      conf_r   <= 8'd0;
      len_r    <= 32'd0;
      remain_r <= 32'd0;
      acc_r    <= 1'b0;
      time_r   <= 32'd0;
      last_r   <= 32'd0;
      count_r  <= 32'd0;
    end else begin
      if (cfg_wr_en) begin
        gap_r <= cfg_wr_data;
      end
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      status_r <= status_nxt;
      class_r  <= class_nxt;
      conf_r   <= conf_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
      acc_r    <= acc_nxt;
      time_r   <= time_nxt;
      last_r   <= last_nxt;
      count_r  <= count_nxt;
    end
  end

  always_comb begin
    res.frame_start      = start;
    res.frame_accepted   = acc_nxt;
    res.frame_status     = status_nxt;
    res.frame_class      = class_nxt;
    res.frame_confidence = conf_nxt;
    res.frame_length     = len_nxt;
    res.frame_count      = count_nxt;
    res.payload_valid    = pvalid;
    res.payload_last     = plast;
    res.payload_byte     = pbyte;
  end

  `MFISP_ASSERT(a_start_no_payload, clk, rst_n, start |-> !pvalid)
  `MFISP_ASSERT(a_last_in_payload, clk, rst_n, plast |-> pvalid && (phase_nxt == PH_HUNT))
  `MFISP_ASSERT(a_skip_one_byte, clk, rst_n,
    (push && !action && (phase_r == PH_SKIP)) |=> (phase_r == PH_HUNT))
  `MFISP_ASSERT(a_count_on_accept, clk, rst_n,
    (count_nxt != count_r) |-> (start && acc_nxt))

endmodule

`default_nettype wire

>>> rtl/core/mfisp_out_stage.sv
// Result register with a skid entry so a new request is taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mfisp_out_stage import mfisp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  result_t   push_res,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output result_t   out_res
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_r;
  result_t skid_r;
  logic    pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r <= push_res;
      end else begin
        skid_r <= push_res;
      end
    end
  end

  `MFISP_ASSERT(a_skid_needs_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `MFISP_ASSERT(a_skid_held, clk, rst_n,
    (skid_valid_r && !pop) |=> (skid_valid_r && $stable(skid_r)))
  `MFISP_ASSERT(a_out_held, clk, rst_n,
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))

endmodule

`default_nettype wire

>>> rtl/core/magic_framed_image_stream_parser_top.sv
// Top level of the framed image stream parser.
// Each result is registered in out_r, or in skid_r while an earlier result waits.
// Throughput: one request per cycle while in_stall is low, set by the single-pass parser.
// The two-entry result stage keeps input taking requests while one result waits.
// Reset (rst_n low, synchronous) clears all parser state and sets the gap to 500 actions.
`timescale 1ns / 1ps
`default_nettype none

module magic_framed_image_stream_parser_top import mfisp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_frame_start,
  output logic             out_frame_accepted,
  output logic [7:0]       out_frame_status,
  output logic [7:0]       out_frame_class,
  output logic [7:0]       out_frame_confidence,
  output logic [31:0]      out_frame_length,
  output logic [31:0]      out_frame_count,
  output logic             out_payload_valid,
  output logic             out_payload_last,
  output logic [7:0]       out_payload_byte,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic    push;
  logic    full;
  result_t core_res;
  result_t out_res;

  assign in_stall = full;
  assign push     = in_valid && !full;

  mfisp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .action      (in_action),
    .data_byte   (in_data_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (core_res)
  );

  mfisp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (core_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_frame_start      = out_res.frame_start;
  assign out_frame_accepted   = out_res.frame_accepted;
  assign out_frame_status     = out_res.frame_status;
  assign out_frame_class      = out_res.frame_class;
  assign out_frame_confidence = out_res.frame_confidence;
  assign out_frame_length     = out_res.frame_length;
  assign out_frame_count      = out_res.frame_count;
  assign out_payload_valid    = out_res.payload_valid;
  assign out_payload_last     = out_res.payload_last;
  assign out_payload_byte     = out_res.payload_byte;

endmodule

`default_nettype wire
